@@ sv/lts_pkg.sv @@
`default_nettype none

package lts_pkg;

    localparam int LTS_MAX_TASKS   = 16;
    localparam int LTS_MAX_TICKETS = 100;
    localparam int LTS_DIV_STEPS   = 32;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_DRAW   = 2'd1;
    localparam logic [1:0] ACT_RETIRE = 2'd2;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_WINNER    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_RETIRED   = 3'd5;
    localparam logic [2:0] ST_ABSENT    = 3'd6;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] first;
        logic [6:0]  cnt;
    } t_entry;

    typedef struct packed {
        logic       load;
        logic       idx_inc;
        logic       div_step;
        logic       add_commit;
        logic       retire_commit;
        logic       emit;
        logic [2:0] status;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       add_full;
        logic       empty;
        logic       slot_free;
        logic       div_last;
        logic       hit;
        logic       idx_last;
    } t_sts;

    // ticket tier from file size, capped at the per-task limit
    function automatic logic [6:0] tier_tickets(input logic [47:0] size);
        logic [6:0] t;
        if (size <= 48'd100) begin
            t = 7'd100;
        end else if (size <= 48'd1000) begin
            t = 7'd75;
        end else if (size <= 48'd1000000) begin
            t = 7'd50;
        end else if (size <= 48'd1000000000) begin
            t = 7'd25;
        end else begin
            t = 7'd10;
        end
        if (t > 7'(LTS_MAX_TICKETS)) begin
            t = 7'(LTS_MAX_TICKETS);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

@@ sv/lottery_ticket_scheduler_core.sv @@
`default_nettype none
// Add is rejected at dispatch when the table is full, else runs a free-slot scan (one entry per
//   cycle); draw runs a 32-step restoring modulo, then a table read and a range check per
//   entry; retire runs the same table read and an id match check per entry.
// Throughput: one transaction at a time; busy is high from acceptance to the result,
//   and the next transaction can be taken in the cycle the result shows.
// Each result shows for one cycle with o_valid; the receiver cannot stall.
// Reset (synchronous, active low) empties the table and zeroes the ticket counter.
module lottery_ticket_scheduler_core #(
    parameter int MAX_TASKS = lts_pkg::LTS_MAX_TASKS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_task_id,
    input  wire logic [47:0] i_file_size,
    input  wire logic [31:0] i_random_word,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [15:0]      o_winner_id,
    output logic [31:0]      o_winning_ticket
);

    import lts_pkg::*;

    // command and status between sequencer and datapath
    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: dispatch on action, run the modulo, walk the table
    lts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // datapath: task table RAM, valid bits, ticket counter, divider, result register
    lts_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_action         (i_action),
        .i_task_id        (i_task_id),
        .i_file_size      (i_file_size),
        .i_random_word    (i_random_word),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_winner_id      (o_winner_id),
        .o_winning_ticket (o_winning_ticket)
    );

    // hold off new work until the current transaction has produced its result
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a transaction in flight");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("accepted transaction did not raise busy");

    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two results for one transaction");

endmodule

`default_nettype wire

@@ sv/lts_ram.sv @@
`default_nettype none

module lts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/lts_datapath.sv @@
`default_nettype none

module lts_datapath #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lts_pkg::t_cmd i_cmd,
    output lts_pkg::t_sts      o_sts,
    input  wire logic [1:0]    i_action,
    input  wire logic [15:0]   i_task_id,
    input  wire logic [47:0]   i_file_size,
    input  wire logic [31:0]   i_random_word,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [15:0]        o_winner_id,
    output logic [31:0]        o_winning_ticket
);

    import lts_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int DW = $clog2(LTS_DIV_STEPS);

    logic [1:0]           r_action;
    logic [15:0]          r_id;
    logic [47:0]          r_size;
    logic [31:0]          r_quo;
    logic [31:0]          r_rem;
    logic [DW-1:0]        r_dcnt;
    logic [31:0]          r_next;
    logic [IW-1:0]        r_idx;
    logic [CW-1:0]        r_count;
    logic [MAX_TASKS-1:0] r_valid;
    logic                 r_o_valid;
    logic [2:0]           r_o_status;
    logic [15:0]          r_o_wid;
    logic [31:0]          r_o_tkt;

    logic [6:0]  w_tickets;
    logic [32:0] w_sum;
    logic [32:0] w_rem_sh;
    logic [32:0] w_rem_sub;
    logic [31:0] w_rem_nx;
    logic [31:0] w_offs;
    logic        w_in_range;
    logic        w_hit;
    t_entry      w_rd;
    t_entry      w_wr;
    logic [15:0] n_wid;
    logic [31:0] n_tkt;

    lts_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_commit),
        .i_waddr (r_idx),
        .i_wdata (w_wr),
        .i_raddr (r_idx),
        .o_rdata (w_rd)
    );

    always_comb begin
        w_tickets  = tier_tickets(r_size);
        w_sum      = {1'b0, r_next} + {26'b0, w_tickets};
        w_wr       = '{id: r_id, first: r_next, cnt: w_tickets};
        // restoring division, one quotient bit per step
        w_rem_sh   = {r_rem, r_quo[31]};
        w_rem_sub  = w_rem_sh - {1'b0, r_next};
        w_rem_nx   = w_rem_sub[32] ? w_rem_sh[31:0] : w_rem_sub[31:0];
        w_offs     = r_rem - w_rd.first;
        w_in_range = (r_rem >= w_rd.first) && (w_offs < {25'b0, w_rd.cnt});
        w_hit      = r_valid[r_idx] &&
                     ((r_action == ACT_DRAW) ? w_in_range : (w_rd.id == r_id));
    end

    assign o_sts = '{
        action:    r_action,
        add_full:  (r_count == CW'(MAX_TASKS)) || w_sum[32],
        empty:     (r_count == '0) || (r_next == '0),
        slot_free: !r_valid[r_idx],
        div_last:  (r_dcnt == DW'(LTS_DIV_STEPS - 1)),
        hit:       w_hit,
        idx_last:  (r_idx == IW'(MAX_TASKS - 1))
    };

    always_comb begin
        case (i_cmd.status) inside
            ST_ADDED: begin
                n_wid = r_id;
                n_tkt = r_next;
            end
            ST_WINNER: begin
                n_wid = w_rd.id;
                n_tkt = r_rem;
            end
            ST_NOT_FOUND: begin
                n_wid = '0;
                n_tkt = r_rem;
            end
            ST_FULL, ST_RETIRED: begin
                n_wid = r_id;
                n_tkt = '0;
            end
            ST_ABSENT: begin
                n_wid = (r_action == ACT_RETIRE) ? r_id : 16'd0;
                n_tkt = '0;
            end
            default: begin
                n_wid = '0;
                n_tkt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_count   <= '0;
            r_next    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.emit;
            if (i_cmd.add_commit) begin
                r_valid[r_idx] <= 1'b1;
                r_count        <= r_count + CW'(1);
                r_next         <= w_sum[31:0];
            end else if (i_cmd.retire_commit) begin
                r_valid[r_idx] <= 1'b0;
                r_count        <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_id     <= i_task_id;
            r_size   <= i_file_size;
            r_quo    <= i_random_word;
            r_rem    <= '0;
            r_dcnt   <= '0;
            r_idx    <= '0;
        end else begin
            if (i_cmd.div_step) begin
                r_rem  <= w_rem_nx;
                r_quo  <= {r_quo[30:0], 1'b0};
                r_dcnt <= r_dcnt + DW'(1);
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
        end
        if (i_cmd.emit) begin
            r_o_status <= i_cmd.status;
            r_o_wid    <= n_wid;
            r_o_tkt    <= n_tkt;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_winner_id      = r_o_wid;
    assign o_winning_ticket = r_o_tkt;

    a_count_tracks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == 32'($countones(r_valid)))
        else $error("task count differs from number of valid entries");

    a_add_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_commit |-> !r_valid[r_idx] && !o_sts.add_full)
        else $error("add committed into a busy slot or a full table");

    a_retire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.retire_commit |-> r_valid[r_idx] && (r_count != '0))
        else $error("retire committed on an invalid entry");

    a_next_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_commit |=> r_next > $past(r_next))
        else $error("ticket counter did not advance on add");

endmodule

`default_nettype wire

@@ sv/lts_ctrl.sv @@
`default_nettype none

module lts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire lts_pkg::t_sts i_sts,
    output lts_pkg::t_cmd      o_cmd
);

    import lts_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_ADD_SCAN = 6'b000100,
        S_DIV      = 6'b001000,
        S_SCAN_RD  = 6'b010000,
        S_SCAN_CHK = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.action)
                    ACT_ADD: begin
                        if (i_sts.add_full) begin
                            w_cmd.emit   = 1'b1;
                            w_cmd.status = ST_FULL;
                            n_state      = S_IDLE;
                        end else begin
                            n_state = S_ADD_SCAN;
                        end
                    end
                    ACT_DRAW: begin
                        if (i_sts.empty) begin
                            w_cmd.emit   = 1'b1;
                            w_cmd.status = ST_EMPTY;
                            n_state      = S_IDLE;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                    ACT_RETIRE: begin
                        n_state = S_SCAN_RD;
                    end
                    default: begin
                        w_cmd.emit   = 1'b1;
                        w_cmd.status = ST_ABSENT;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_ADD_SCAN: begin
                if (i_sts.slot_free) begin
                    w_cmd.add_commit = 1'b1;
                    w_cmd.emit       = 1'b1;
                    w_cmd.status     = ST_ADDED;
                    n_state          = S_IDLE;
                end else begin
                    w_cmd.idx_inc = 1'b1;
                end
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.hit) begin
                    w_cmd.emit          = 1'b1;
                    w_cmd.retire_commit = (i_sts.action == ACT_RETIRE);
                    w_cmd.status        = (i_sts.action == ACT_DRAW) ? ST_WINNER : ST_RETIRED;
                    n_state             = S_IDLE;
                end else if (i_sts.idx_last) begin
                    w_cmd.emit   = 1'b1;
                    w_cmd.status = (i_sts.action == ACT_DRAW) ? ST_NOT_FOUND : ST_ABSENT;
                    n_state      = S_IDLE;
                end else begin
                    w_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = w_cmd;
    assign busy  = (r_state != S_IDLE);

    a_start_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && start |=> (r_state == S_DISPATCH))
        else $error("accepted transaction did not reach dispatch");

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> (r_state == S_IDLE))
        else $error("controller kept working after a result");

    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> busy && !w_cmd.load)
        else $error("result issued while idle");

endmodule

`default_nettype wire
